// ----- rtl/pmsc_pkg.sv -----
// ----------------------------------------------------------------------------
// pmsc_pkg: shared types and constants for the servo command unit
// Field widths, scaling constants, controller states, datapath operations
// and the exact divide-by-1023 helper used by both scaling steps.
// ----------------------------------------------------------------------------
package pmsc_pkg;

  // Field widths of the input and result beats.
  localparam int SAMPLE_W = 10;
  localparam int SPEED_W  = 8;
  localparam int MAG_W    = 7;
  localparam int ANGLE_W  = 8;
  localparam int MOTOR_W  = 11;
  localparam int SERVO_W  = 14;

  // Width of an average times a span constant (at most 1023 * 198).
  localparam int SCALED_W = 18;

  // Scaling constants.
  localparam int SPEED_SPAN = 198;
  localparam int SPEED_HALF = 99;
  localparam int ANGLE_SPAN = 180;
  localparam int ANGLE_HALF = 90;
  localparam int MOTOR_TOP  = 1999;
  localparam int MOTOR_DIV  = 99;
  localparam int SERVO_TOP  = 13499;
  localparam int SERVO_BASE = 2999;
  localparam int SERVO_STEP = (SERVO_TOP - SERVO_BASE) / ANGLE_SPAN;

  // magnitude * 1999 / 99 is split as magnitude * 20 + (magnitude * 19) / 99.
  // The second part is small, so the divide by 99 is an exact reciprocal
  // multiply with an 18-bit shift.
  localparam int MOTOR_WHOLE = MOTOR_TOP / MOTOR_DIV;
  localparam int MOTOR_FRAC  = MOTOR_TOP % MOTOR_DIV;
  localparam int FRAC_W      = 11;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = 12;
  localparam int RECIP_99    = (2 ** RECIP_SHIFT + MOTOR_DIV - 1) / MOTOR_DIV;
  localparam int QUOT_W      = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_SPEED,
    ST_AVG_ANGLE,
    ST_SCALE_SPEED,
    ST_SCALE_ANGLE,
    ST_DIRECTION,
    ST_MOTOR,
    ST_RESULT
  } pmsc_state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_AVG_SPEED,
    OP_AVG_ANGLE,
    OP_SCALE_SPEED,
    OP_SCALE_ANGLE,
    OP_DIRECTION,
    OP_MOTOR
  } pmsc_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic     load;
    pmsc_op_t op;
    logic     emit;
  } pmsc_cmd_t;

  // One result beat.
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_setting;
    logic [MAG_W-1:0]          speed_magnitude;
    logic signed [ANGLE_W-1:0] angle_setting;
    logic [ANGLE_W-1:0]        angle_absolute;
    logic                      bridge_enable;
    logic                      bridge_in_a;
    logic                      bridge_in_b;
    logic [MOTOR_W-1:0]        motor_pulse;
    logic [SERVO_W-1:0]        servo_pulse;
  } pmsc_result_t;

  // Exact floor(x / 1023) for x below 1024 * 1023: with 1023 = 2^10 - 1,
  // the quotient is (x + (x >> 10) + 1) >> 10.
  function automatic logic [ANGLE_W-1:0] div1023(input logic [SCALED_W-1:0] x);
    logic [SCALED_W:0] s;
    s = {1'b0, x} + (SCALED_W + 1)'(x[SCALED_W-1:10]) + (SCALED_W + 1)'(1);
    return s[SCALED_W-1:10];
  endfunction

endpackage

// ----- rtl/pmsc_if.sv -----
// ----------------------------------------------------------------------------
// pmsc_if: channel interfaces of the servo command unit
// Valid/ready channels for the sample beats and the command beats.
// ----------------------------------------------------------------------------
interface pmsc_in_if;
  logic                            valid;
  logic                            ready;
  logic [pmsc_pkg::SAMPLE_W-1:0]   speed_sample;
  logic [pmsc_pkg::SAMPLE_W-1:0]   angle_sample;

  modport source (output valid, speed_sample, angle_sample, input ready);
  modport sink (input valid, speed_sample, angle_sample, output ready);
endinterface

interface pmsc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pmsc_pkg::SPEED_W-1:0]  speed_setting;
  logic [pmsc_pkg::MAG_W-1:0]           speed_magnitude;
  logic signed [pmsc_pkg::ANGLE_W-1:0]  angle_setting;
  logic [pmsc_pkg::ANGLE_W-1:0]         angle_absolute;
  logic                                 bridge_enable;
  logic                                 bridge_in_a;
  logic                                 bridge_in_b;
  logic [pmsc_pkg::MOTOR_W-1:0]         motor_pulse;
  logic [pmsc_pkg::SERVO_W-1:0]         servo_pulse;

  modport source (output valid, speed_setting, speed_magnitude, angle_setting,
                  angle_absolute, bridge_enable, bridge_in_a, bridge_in_b,
                  motor_pulse, servo_pulse, input ready);
  modport sink (input valid, speed_setting, speed_magnitude, angle_setting,
                angle_absolute, bridge_enable, bridge_in_a, bridge_in_b,
                motor_pulse, servo_pulse, output ready);
endinterface

// ----- rtl/pmsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// pmsc_ctrl: sequencing controller of the servo command unit
// Steps the datapath through averaging, scaling and pulse computation and
// owns the valid flag of the result register.
// ----------------------------------------------------------------------------
module pmsc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output pmsc_pkg::pmsc_cmd_t cmd
);

  pmsc_pkg::pmsc_state_t state;
  pmsc_pkg::pmsc_state_t state_next;
  logic                  out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pmsc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.op     = pmsc_pkg::OP_NONE;
    cmd.emit   = 1'b0;
    unique case (state)
      pmsc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = pmsc_pkg::ST_AVG_SPEED;
        end
      end
      pmsc_pkg::ST_AVG_SPEED: begin
        cmd.op     = pmsc_pkg::OP_AVG_SPEED;
        state_next = pmsc_pkg::ST_AVG_ANGLE;
      end
      pmsc_pkg::ST_AVG_ANGLE: begin
        cmd.op     = pmsc_pkg::OP_AVG_ANGLE;
        state_next = pmsc_pkg::ST_SCALE_SPEED;
      end
      pmsc_pkg::ST_SCALE_SPEED: begin
        cmd.op     = pmsc_pkg::OP_SCALE_SPEED;
        state_next = pmsc_pkg::ST_SCALE_ANGLE;
      end
      pmsc_pkg::ST_SCALE_ANGLE: begin
        cmd.op     = pmsc_pkg::OP_SCALE_ANGLE;
        state_next = pmsc_pkg::ST_DIRECTION;
      end
      pmsc_pkg::ST_DIRECTION: begin
        cmd.op     = pmsc_pkg::OP_DIRECTION;
        state_next = pmsc_pkg::ST_MOTOR;
      end
      pmsc_pkg::ST_MOTOR: begin
        cmd.op     = pmsc_pkg::OP_MOTOR;
        state_next = pmsc_pkg::ST_RESULT;
      end
      pmsc_pkg::ST_RESULT: begin
        // The result register takes a new beat once its old one is gone
        // or leaves in this very cycle.
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = pmsc_pkg::ST_IDLE;
        end
      end
      default: state_next = pmsc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ----- rtl/pmsc_datapath.sv -----
// ----------------------------------------------------------------------------
// pmsc_datapath: windows, scaling arithmetic and result register
// Holds both moving-average windows with their running sums, performs one
// arithmetic step per command and loads the result register on emit.
// ----------------------------------------------------------------------------
module pmsc_datapath #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  input  pmsc_pkg::pmsc_cmd_t               cmd,
  input  logic [pmsc_pkg::SAMPLE_W-1:0]     speed_sample,
  input  logic [pmsc_pkg::SAMPLE_W-1:0]     angle_sample,
  output pmsc_pkg::pmsc_result_t            result
);

  localparam int SW = pmsc_pkg::SAMPLE_W;
  // Running sum of a full window.
  localparam int SUM_W = $clog2(WINDOW_DEPTH * (2 ** SW - 1) + 1);
  // floor(sum / depth) = (sum * AVG_MUL) >> AVG_SHIFT, exact for every sum.
  localparam int AVG_SHIFT = SUM_W + 5;
  localparam int MUL_W = AVG_SHIFT - $clog2(WINDOW_DEPTH) + 1;
  localparam int PROD_W = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] AVG_MUL =
    MUL_W'((2 ** AVG_SHIFT + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  logic [SW-1:0]    speed_win [WINDOW_DEPTH];
  logic [SW-1:0]    angle_win [WINDOW_DEPTH];
  logic [SUM_W-1:0] speed_sum;
  logic [SUM_W-1:0] angle_sum;
  logic             dir_a;
  logic             dir_b;

  logic [PROD_W-1:0]                    prod;
  logic [SW-1:0]                        speed_avg;
  logic [SW-1:0]                        angle_avg;
  logic [pmsc_pkg::SCALED_W-1:0]        scaled;
  logic signed [pmsc_pkg::SPEED_W-1:0]  speed_cmd;
  logic [pmsc_pkg::MAG_W-1:0]           speed_mag;
  logic [pmsc_pkg::ANGLE_W-1:0]         angle_abs;
  logic                                 enable;
  logic [pmsc_pkg::FRAC_W-1:0]          frac_prod;
  logic [pmsc_pkg::SERVO_W-1:0]         servo_val;

  logic [pmsc_pkg::ANGLE_W-1:0]         quot1023;
  logic signed [pmsc_pkg::SPEED_W:0]    speed_wide;
  logic [pmsc_pkg::MAG_W-1:0]           mag_next;
  logic [pmsc_pkg::FRAC_W+pmsc_pkg::RECIP_W-1:0] recip_prod;
  logic [pmsc_pkg::QUOT_W-1:0]          motor_quot;
  logic [pmsc_pkg::MOTOR_W-1:0]         motor_val;

  assign quot1023   = pmsc_pkg::div1023(scaled);
  assign speed_wide = $signed({1'b0, quot1023})
                      - $signed((pmsc_pkg::SPEED_W + 1)'(pmsc_pkg::SPEED_HALF));
  assign mag_next   = speed_cmd[pmsc_pkg::SPEED_W-1] ? pmsc_pkg::MAG_W'(-speed_cmd)
                                                      : pmsc_pkg::MAG_W'(speed_cmd);
  assign recip_prod = (pmsc_pkg::FRAC_W + pmsc_pkg::RECIP_W)'(frac_prod)
                      * (pmsc_pkg::FRAC_W + pmsc_pkg::RECIP_W)'(pmsc_pkg::RECIP_99);
  assign motor_quot = recip_prod[pmsc_pkg::RECIP_SHIFT +: pmsc_pkg::QUOT_W];
  assign motor_val  = pmsc_pkg::MOTOR_W'(speed_mag) * pmsc_pkg::MOTOR_W'(pmsc_pkg::MOTOR_WHOLE)
                      + pmsc_pkg::MOTOR_W'(motor_quot);

  // Windows, sums and direction state: cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        speed_win[i] <= '0;
        angle_win[i] <= '0;
      end
      speed_sum <= '0;
      angle_sum <= '0;
      dir_a     <= 1'b0;
      dir_b     <= 1'b0;
    end else begin
      if (cmd.load) begin
        speed_win[0] <= speed_sample;
        angle_win[0] <= angle_sample;
        for (int i = 1; i < WINDOW_DEPTH; i++) begin
          speed_win[i] <= speed_win[i-1];
          angle_win[i] <= angle_win[i-1];
        end
        speed_sum <= speed_sum + SUM_W'(speed_sample) - SUM_W'(speed_win[WINDOW_DEPTH-1]);
        angle_sum <= angle_sum + SUM_W'(angle_sample) - SUM_W'(angle_win[WINDOW_DEPTH-1]);
      end
      if (cmd.op == pmsc_pkg::OP_DIRECTION && speed_cmd != '0) begin
        dir_a <= !speed_cmd[pmsc_pkg::SPEED_W-1];
        dir_b <= speed_cmd[pmsc_pkg::SPEED_W-1];
      end
    end
  end

  // Arithmetic steps, one per command.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pmsc_pkg::OP_AVG_SPEED: begin
        prod <= PROD_W'(speed_sum) * PROD_W'(AVG_MUL);
      end
      pmsc_pkg::OP_AVG_ANGLE: begin
        speed_avg <= prod[AVG_SHIFT +: SW];
        prod      <= PROD_W'(angle_sum) * PROD_W'(AVG_MUL);
      end
      pmsc_pkg::OP_SCALE_SPEED: begin
        angle_avg <= prod[AVG_SHIFT +: SW];
        scaled    <= pmsc_pkg::SCALED_W'(speed_avg) * pmsc_pkg::SCALED_W'(pmsc_pkg::SPEED_SPAN);
      end
      pmsc_pkg::OP_SCALE_ANGLE: begin
        speed_cmd <= speed_wide[pmsc_pkg::SPEED_W-1:0];
        scaled    <= pmsc_pkg::SCALED_W'(angle_avg) * pmsc_pkg::SCALED_W'(pmsc_pkg::ANGLE_SPAN);
      end
      pmsc_pkg::OP_DIRECTION: begin
        speed_mag <= mag_next;
        angle_abs <= quot1023;
        enable    <= (speed_cmd != '0);
      end
      pmsc_pkg::OP_MOTOR: begin
        frac_prod <= pmsc_pkg::FRAC_W'(speed_mag) * pmsc_pkg::FRAC_W'(pmsc_pkg::MOTOR_FRAC);
        servo_val <= pmsc_pkg::SERVO_W'(angle_abs) * pmsc_pkg::SERVO_W'(pmsc_pkg::SERVO_STEP)
                     + pmsc_pkg::SERVO_W'(pmsc_pkg::SERVO_BASE);
      end
      pmsc_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result.speed_setting   <= speed_cmd;
      result.speed_magnitude <= speed_mag;
      result.angle_setting   <= pmsc_pkg::ANGLE_W'(angle_abs)
                                - pmsc_pkg::ANGLE_W'(pmsc_pkg::ANGLE_HALF);
      result.angle_absolute  <= angle_abs;
      result.bridge_enable   <= enable;
      result.bridge_in_a     <= dir_a;
      result.bridge_in_b     <= dir_b;
      result.motor_pulse     <= motor_val;
      result.servo_pulse     <= servo_val;
    end
  end

endmodule

// ----- rtl/pot_to_motor_servo_command_unit.sv -----
// ----------------------------------------------------------------------------
// pot_to_motor_servo_command_unit: potentiometer to motor and servo commands
// Averages speed and angle potentiometer readings and turns them into
// H-bridge control bits, a DC-motor compare value and a servo compare value.
// ----------------------------------------------------------------------------

// Each sample beat carries one speed and one angle reading of 10 bits. Both
// readings enter moving-average windows of WINDOW_DEPTH entries that reset
// clears to zero, so the averages ramp up from zero after reset. An accepted
// beat first loads the windows, then passes through six steps of a
// controller that drives a single arithmetic step per cycle (two reciprocal
// multiplies for the averages, two scalings with an exact divide by 1023,
// the direction update, the motor and servo products), and then loads the
// result register. The sample channel is ready only while the controller is
// idle, so a new beat is taken only once the previous one has been loaded
// into the result register; a finished result may wait in the output
// register while the next beat is already being worked on. The direction
// bits keep their last values while the speed command is zero, and both
// read zero until the first nonzero speed.
module pot_to_motor_servo_command_unit #(
  parameter int WINDOW_DEPTH = 10
) (
  input  logic           clk,
  input  logic           rst,
  pmsc_in_if.sink        samples,
  pmsc_out_if.source     command
);

  pmsc_pkg::pmsc_cmd_t    cmd;
  pmsc_pkg::pmsc_result_t result;

  // The controller sequences the work and owns both handshakes.
  pmsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (command.valid),
    .out_ready (command.ready),
    .cmd       (cmd)
  );

  // The datapath holds the windows and computes the command fields.
  pmsc_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .speed_sample (samples.speed_sample),
    .angle_sample (samples.angle_sample),
    .result       (result)
  );

  // The result register drives the command beat directly.
  assign command.speed_setting   = result.speed_setting;
  assign command.speed_magnitude = result.speed_magnitude;
  assign command.angle_setting   = result.angle_setting;
  assign command.angle_absolute  = result.angle_absolute;
  assign command.bridge_enable   = result.bridge_enable;
  assign command.bridge_in_a     = result.bridge_in_a;
  assign command.bridge_in_b     = result.bridge_in_b;
  assign command.motor_pulse     = result.motor_pulse;
  assign command.servo_pulse     = result.servo_pulse;

`ifndef NO_ASSERTIONS
  // One beat at a time: after an accepted sample the channel closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("sample channel stayed open after an accepted beat");

  // The bridge is enabled exactly when the speed command is nonzero.
  a_enable_matches_speed: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> (command.bridge_enable == (command.speed_setting != '0)))
    else $error("bridge enable disagrees with speed command");

  // The direction inputs never drive both bridge legs at once.
  a_no_shoot_through: assert property (@(posedge clk) disable iff (rst)
    command.valid |-> !(command.bridge_in_a && command.bridge_in_b))
    else $error("both bridge direction inputs high");

  // A result is loaded only when the slot is free or is being emptied.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!command.valid || command.ready))
    else $error("result register overwritten before delivery");
`endif

endmodule
